/* rtl/rgb_contrast_stretch_defines.svh */
// Assertion macros for the contrast stretch RTL.
// Used by rcs_fifo and rcs_back; expects clk and arst_n in scope.
`ifndef RGB_CONTRAST_STRETCH_DEFINES_SVH
`define RGB_CONTRAST_STRETCH_DEFINES_SVH
`ifndef SYNTHESIS
// checked only out of reset
`define RCS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked at every edge, reset included
`define RCS_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RCS_ASSERT(lbl, prop, msg)
`define RCS_ASSERT_RST(lbl, prop, msg)
`endif
`endif

/* rtl/rcs_pkg.sv */
// Shared types and constants for the RGB contrast stretch.
// No dependencies.
`default_nettype none
package rcs_pkg;
	localparam int PIX_W    = 8;
	localparam int CHANNELS = 3;
	localparam int NUM_W    = 2 * PIX_W;            // 255 * (v - low)
	localparam int STEPS    = PIX_W;                // quotient bits
	localparam int STEP_W   = $clog2(STEPS);
	localparam int DSH_W    = PIX_W + STEPS - 1;    // den << (STEPS-1)
	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCNT_W   = $clog2(QDEPTH + 1);

	localparam logic [PIX_W-1:0] FULL_SCALE = 8'd255;
	localparam logic [PIX_W-1:0] LOW_INIT   = 8'd255;
	localparam logic [PIX_W-1:0] HIGH_INIT  = 8'd0;

	typedef logic [PIX_W-1:0] pix_t;

	typedef enum logic [1:0] {
		CLS_ZERO,
		CLS_FULL,
		CLS_DIV
	} cls_t;

	typedef struct packed {
		logic [CHANNELS-1:0][NUM_W-1:0] num;
		cls_t [CHANNELS-1:0]            cls;
		pix_t                           den;
		logic                           last;
	} entry_t;
endpackage
`default_nettype wire

/* rtl/rcs_front.sv */
// Front end: takes pixels, tracks min/max in measure pass, classifies map pixels.
// Depends on rcs_pkg.
`default_nettype none
module rcs_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  logic            full,
	input  logic            operation,
	input  rcs_pkg::pix_t   red_in,
	input  rcs_pkg::pix_t   green_in,
	input  rcs_pkg::pix_t   blue_in,
	input  logic            frame_end,
	output logic            wr_en,
	output rcs_pkg::entry_t wr_data
);
	import rcs_pkg::*;

	pix_t running_low_q, running_high_q, latched_low_q, latched_high_q;
	pix_t pix [CHANNELS];
	pix_t lo_nx, hi_nx, den, diff;
	logic accept, flat;

	assign pix[0] = red_in;
	assign pix[1] = green_in;
	assign pix[2] = blue_in;

	assign accept = push && !full;
	assign wr_en  = accept && operation;

	always_comb begin
		lo_nx = running_low_q;
		hi_nx = running_high_q;
		for (int c = 0; c < CHANNELS; c++) begin
			if (pix[c] < lo_nx) lo_nx = pix[c];
			if (pix[c] > hi_nx) hi_nx = pix[c];
		end
	end

	assign flat = latched_high_q <= latched_low_q;
	assign den  = latched_high_q - latched_low_q;

	always_comb begin
		diff = '0;
		wr_data.den  = den;
		wr_data.last = frame_end;
		for (int c = 0; c < CHANNELS; c++) begin
			diff = pix[c] - latched_low_q;
			// 255*x as (x << 8) - x
			wr_data.num[c] = {diff, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, diff};
			if (flat || pix[c] <= latched_low_q)
				wr_data.cls[c] = CLS_ZERO;
			else if (pix[c] >= latched_high_q)
				wr_data.cls[c] = CLS_FULL;
			else
				wr_data.cls[c] = CLS_DIV;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_low_q  <= LOW_INIT;
			running_high_q <= HIGH_INIT;
			latched_low_q  <= HIGH_INIT;
			latched_high_q <= LOW_INIT;
		end else if (accept && !operation) begin
			if (frame_end) begin
				latched_low_q  <= lo_nx;
				latched_high_q <= hi_nx;
				running_low_q  <= LOW_INIT;
				running_high_q <= HIGH_INIT;
			end else begin
				running_low_q  <= lo_nx;
				running_high_q <= hi_nx;
			end
		end
	end
endmodule
`default_nettype wire

/* rtl/rcs_fifo.sv */
// Short queue of classified map requests between front and back.
// Depends on rcs_pkg and rgb_contrast_stretch_defines.svh.
`default_nettype none
`include "rgb_contrast_stretch_defines.svh"
module rcs_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  rcs_pkg::entry_t wr_data,
	output logic            full,
	input  logic            rd_en,
	output rcs_pkg::entry_t rd_data,
	output logic            empty
);
	import rcs_pkg::*;

	entry_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wptr_q, rptr_q;
	logic [QCNT_W-1:0]  cnt_q;

	assign full    = cnt_q == QCNT_W'(QDEPTH);
	assign empty   = cnt_q == '0;
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr_en)
				wptr_q <= (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (rd_en)
				rptr_q <= (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
			if (wr_en && !rd_en)
				cnt_q <= cnt_q + 1'b1;
			else if (rd_en && !wr_en)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	`RCS_ASSERT(a_cnt_max, cnt_q <= QCNT_W'(QDEPTH), "queue count above depth")
	`RCS_ASSERT(a_cnt_up, wr_en && !rd_en |=> cnt_q == $past(cnt_q) + QCNT_W'(1), "count lost a write")
endmodule
`default_nettype wire

/* rtl/rcs_back.sv */
// Back end: 8-step shift-subtract divide per channel, round half to even, output register.
// Depends on rcs_pkg and rgb_contrast_stretch_defines.svh.
`default_nettype none
`include "rgb_contrast_stretch_defines.svh"
module rcs_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  rcs_pkg::entry_t q_data,
	output logic            q_pop,
	input  logic            pop,
	output logic            empty,
	output rcs_pkg::pix_t   red_out,
	output rcs_pkg::pix_t   green_out,
	output rcs_pkg::pix_t   blue_out,
	output logic            last_out
);
	import rcs_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_HOLD
	} state_t;

	state_t             state_q;
	logic [STEP_W-1:0]  step_q;
	logic               out_valid_q;
	logic [NUM_W-1:0]   rem_q [CHANNELS];
	pix_t               quo_q [CHANNELS];
	cls_t               cls_q [CHANNELS];
	logic [DSH_W-1:0]   dsh_q;
	pix_t               den_q;
	logic               last_q;

	logic [NUM_W-1:0]   rem_nx [CHANNELS];
	logic               qbit [CHANNELS];
	pix_t               res [CHANNELS];
	logic               out_take;

	assign q_pop    = state_q == S_IDLE && !q_empty;
	assign out_take = state_q == S_HOLD && (!out_valid_q || pop);
	assign empty    = !out_valid_q;

	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			qbit[c]   = rem_q[c] >= NUM_W'(dsh_q);
			rem_nx[c] = qbit[c] ? rem_q[c] - NUM_W'(dsh_q) : rem_q[c];
		end
	end

	always_comb begin
		logic [PIX_W:0] r2;
		logic [PIX_W:0] d2;
		logic           up;
		for (int c = 0; c < CHANNELS; c++) begin
			r2 = {rem_q[c][PIX_W-1:0], 1'b0};
			d2 = {1'b0, den_q};
			up = (r2 > d2) || (r2 == d2 && quo_q[c][0]);
			case (cls_q[c])
				CLS_ZERO: res[c] = '0;
				CLS_FULL: res[c] = FULL_SCALE;
				CLS_DIV:  res[c] = quo_q[c] + PIX_W'(up);   // quotient <= 254
				default:  res[c] = '0;
			endcase
		end
	end

	// divider datapath
	always_ff @(posedge clk) begin
		if (q_pop) begin
			for (int c = 0; c < CHANNELS; c++) begin
				rem_q[c] <= q_data.num[c];
				quo_q[c] <= '0;
				cls_q[c] <= q_data.cls[c];
			end
			dsh_q  <= {q_data.den, {(STEPS-1){1'b0}}};
			den_q  <= q_data.den;
			last_q <= q_data.last;
		end else if (state_q == S_DIV) begin
			for (int c = 0; c < CHANNELS; c++) begin
				rem_q[c] <= rem_nx[c];
				quo_q[c] <= {quo_q[c][PIX_W-2:0], qbit[c]};
			end
			dsh_q <= dsh_q >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
			red_out     <= '0;
			green_out   <= '0;
			blue_out    <= '0;
			last_out    <= 1'b0;
		end else begin
			if (pop && out_valid_q && !out_take) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						state_q <= S_DIV;
						step_q  <= STEP_W'(STEPS - 1);
					end
				end
				S_DIV: begin
					if (step_q == '0) state_q <= S_HOLD;
					else step_q <= step_q - 1'b1;
				end
				S_HOLD: begin
					if (out_take) begin
						red_out     <= res[0];
						green_out   <= res[1];
						blue_out    <= res[2];
						last_out    <= last_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`RCS_ASSERT_RST(a_rst_idle, !arst_n |-> state_q == S_IDLE && !out_valid_q, "not idle in reset")
	`RCS_ASSERT(a_div_len, state_q == S_DIV && step_q == '0 |=> state_q == S_HOLD, "divide overran")
	`RCS_ASSERT(a_rem_bound, state_q == S_HOLD && cls_q[0] == CLS_DIV |-> rem_q[0] < NUM_W'(den_q), "remainder not reduced")
	`RCS_ASSERT(a_keep_result, out_valid_q && !pop |=> out_valid_q, "waiting result dropped")
endmodule
`default_nettype wire

/* rtl/rgb_contrast_stretch.sv */
// Top level of the RGB min/max contrast stretch.
// Depends on rcs_pkg, rcs_front, rcs_fifo, rcs_back.
//
// channel  | handshake        | payload
// ---------+------------------+-----------------------------------------------
// input    | push / full      | operation, red_in, green_in, blue_in, frame_end
// result   | pop / empty      | red_out, green_out, blue_out, last_out
//
// A measure pixel is absorbed by the front end and gives no result.
// In the back end a map pixel goes through a load, eight shift-subtract steps
// of the shared three-channel divider and a round-and-write step.
// A four-entry queue lets the front keep taking pixels while the divider runs.
// Reset is asynchronous and leaves the identity mapping (extremes 0 and 255).
// full follows the queue; a waiting result stalls the divider only at write-back.
`default_nettype none
module rgb_contrast_stretch (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic          operation,
	input  rcs_pkg::pix_t red_in,
	input  rcs_pkg::pix_t green_in,
	input  rcs_pkg::pix_t blue_in,
	input  logic          frame_end,
	output logic          empty,
	input  logic          pop,
	output rcs_pkg::pix_t red_out,
	output rcs_pkg::pix_t green_out,
	output rcs_pkg::pix_t blue_out,
	output logic          last_out
);
	import rcs_pkg::*;

	logic   wr_en, q_pop, q_empty;
	entry_t wr_data, q_data;

	rcs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.operation (operation),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.frame_end (frame_end),
		.wr_en     (wr_en),
		.wr_data   (wr_data)
	);

	rcs_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (wr_data),
		.full    (full),
		.rd_en   (q_pop),
		.rd_data (q_data),
		.empty   (q_empty)
	);

	rcs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.pop       (pop),
		.empty     (empty),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out),
		.last_out  (last_out)
	);
endmodule
`default_nettype wire

/* verif/tb_rgb_contrast_stretch.sv */
// Self-checking testbench for rgb_contrast_stretch: measure and map pixels go in
// through the push/full queue, stretched pixels are checked at the pop/empty side.
// Depends on rcs_pkg and the rgb_contrast_stretch RTL.
`default_nettype none
module tb_rgb_contrast_stretch;
	timeunit 1ns;
	timeprecision 1ps;

	import rcs_pkg::*;

	typedef enum logic {
		OP_MEASURE = 1'b0,
		OP_MAP     = 1'b1
	} pass_op_t;

	typedef struct {
		pix_t red;
		pix_t green;
		pix_t blue;
		logic last;
	} mapped_px_t;

	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_CYCLES = 300;
	localparam int ITEM_TARGET = 850;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	logic operation;
	pix_t red_in;
	pix_t green_in;
	pix_t blue_in;
	logic frame_end;
	logic empty;
	logic pop;
	pix_t red_out;
	pix_t green_out;
	pix_t blue_out;
	logic last_out;

	// predictor state
	pix_t run_lo = LOW_INIT;
	pix_t run_hi = HIGH_INIT;
	pix_t lat_lo = 8'd0;
	pix_t lat_hi = FULL_SCALE;
	mapped_px_t expected_px[$];

	int errors = 0;
	int sent = 0;
	int measure_seen = 0;
	int map_seen = 0;
	int results_checked = 0;
	int full_stalls = 0;
	int cycles = 0;
	bit calm = 1'b0;
	bit hold_req = 1'b0;

	rgb_contrast_stretch u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.operation (operation),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.frame_end (frame_end),
		.empty     (empty),
		.pop       (pop),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out),
		.last_out  (last_out)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// mostly no gap, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic pix_t stretch_value(pix_t v);
		int den, num, q, r;
		if (lat_hi <= lat_lo || v <= lat_lo)
			return 8'd0;
		if (v >= lat_hi)
			return FULL_SCALE;
		den = int'(lat_hi) - int'(lat_lo);
		num = int'(FULL_SCALE) * (int'(v) - int'(lat_lo));
		q = num / den;
		r = num % den;
		// round half to even
		if (2 * r > den || (2 * r == den && q % 2 == 1))
			q++;
		if (q > int'(FULL_SCALE))
			q = int'(FULL_SCALE);
		return pix_t'(q);
	endfunction

	function automatic pix_t near_range(int lo, int hi);
		int v;
		v = lo - 4 + int'($urandom_range(0, hi - lo + 8));
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return pix_t'(v);
	endfunction

	// request monitor, predictor and result checker
	always @(posedge clk) begin
		pix_t chan[3];
		mapped_px_t want;
		if (arst_n) begin
			if (!empty && pop) begin
				results_checked++;
				if (expected_px.size() == 0) begin
					$error("result with nothing expected: %0d %0d %0d last %0b",
						red_out, green_out, blue_out, last_out);
					errors++;
				end else begin
					want = expected_px.pop_front();
					if (red_out !== want.red) begin
						$error("red_out expected %0d got %0d", want.red, red_out);
						errors++;
					end
					if (green_out !== want.green) begin
						$error("green_out expected %0d got %0d", want.green, green_out);
						errors++;
					end
					if (blue_out !== want.blue) begin
						$error("blue_out expected %0d got %0d", want.blue, blue_out);
						errors++;
					end
					if (last_out !== want.last) begin
						$error("last_out expected %0b got %0b", want.last, last_out);
						errors++;
					end
				end
			end
			if (push && full)
				full_stalls++;
			if (push && !full) begin
				chan = '{red_in, green_in, blue_in};
				if (operation == OP_MEASURE) begin
					measure_seen++;
					foreach (chan[c]) begin
						if (chan[c] < run_lo)
							run_lo = chan[c];
						if (chan[c] > run_hi)
							run_hi = chan[c];
					end
					if (frame_end) begin
						lat_lo = run_lo;
						lat_hi = run_hi;
						run_lo = LOW_INIT;
						run_hi = HIGH_INIT;
					end
				end else begin
					map_seen++;
					expected_px.push_back('{stretch_value(red_in), stretch_value(green_in),
						stretch_value(blue_in), frame_end});
				end
			end
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		int stall_left;
		int hold_left;
		bit hold_seen;
		stall_left = 0;
		hold_left = 0;
		hold_seen = 1'b0;
		pop <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (!arst_n) begin
				pop <= 1'b0;
			end else if (hold_left > 0) begin
				pop <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				pop <= 1'b0;
				stall_left--;
			end else begin
				pop <= 1'b1;
				stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
			end
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycles, expected_px.size());
		$display("status: fail");
		$finish;
	end

	task automatic send_pixel(input pass_op_t op, input pix_t r, input pix_t g, input pix_t b,
		input logic fe);
		int gap;
		operation <= op;
		red_in <= r;
		green_in <= g;
		blue_in <= b;
		frame_end <= fe;
		push <= 1'b1;
		do @(posedge clk); while (full);
		sent++;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (expected_px.size() != 0)
			@(posedge clk);
	endtask

	// reset extremes 0 and 255 give the identity mapping
	task automatic test_identity_after_reset();
		send_pixel(OP_MAP, 8'd0, 8'd128, 8'd255, 1'b0);
		send_pixel(OP_MAP, 8'd1, 8'd254, 8'd127, 1'b1);
	endtask

	task automatic test_directed_cases();
		// extremes 10..16: half cases round to even both ways, clamps below and above
		send_pixel(OP_MEASURE, 8'd10, 8'd16, 8'd12, 1'b0);
		send_pixel(OP_MEASURE, 8'd13, 8'd14, 8'd15, 1'b1);
		send_pixel(OP_MAP, 8'd11, 8'd13, 8'd10, 1'b0);
		send_pixel(OP_MAP, 8'd16, 8'd9, 8'd17, 1'b1);
		send_pixel(OP_MAP, 8'd14, 8'd12, 8'd15, 1'b0);
		// flat frame maps everything to zero
		send_pixel(OP_MEASURE, 8'd77, 8'd77, 8'd77, 1'b1);
		send_pixel(OP_MAP, 8'd77, 8'd0, 8'd255, 1'b1);
		// running extremes must restart after a latch
		send_pixel(OP_MEASURE, 8'd0, 8'd255, 8'd9, 1'b1);
		send_pixel(OP_MEASURE, 8'd100, 8'd102, 8'd101, 1'b1);
		send_pixel(OP_MAP, 8'd101, 8'd100, 8'd102, 1'b1);
		// full-range frame is the identity again
		send_pixel(OP_MEASURE, 8'd255, 8'd0, 8'd128, 1'b1);
		send_pixel(OP_MAP, 8'd255, 8'd0, 8'd1, 1'b0);
		send_pixel(OP_MAP, 8'd170, 8'd85, 8'd254, 1'b1);
	endtask

	// well-formed measure/map frame pairs with random content, plus noise
	task automatic test_random_frames(input int target);
		int lo, hi, span, n, m;
		while (sent < target) begin
			if ($urandom_range(0, 9) == 0) begin
				send_pixel(pass_op_t'($urandom_range(0, 1)), pix_t'($urandom), pix_t'($urandom),
					pix_t'($urandom), 1'($urandom_range(0, 1)));
			end else begin
				lo = $urandom_range(0, 255);
				case ($urandom_range(0, 3))
					0: span = $urandom_range(0, 2);
					1: span = $urandom_range(3, 20);
					2: span = $urandom_range(0, 255);
					default: begin
						lo = 0;
						span = 255;
					end
				endcase
				hi = (lo + span > 255) ? 255 : lo + span;
				n = $urandom_range(1, 10);
				for (int i = 0; i < n; i++)
					send_pixel(OP_MEASURE, pix_t'(lo + $urandom_range(0, hi - lo)),
						pix_t'(lo + $urandom_range(0, hi - lo)),
						pix_t'(lo + $urandom_range(0, hi - lo)),
						(i == n - 1) && ($urandom_range(0, 19) != 0));
				m = $urandom_range(1, 10);
				for (int i = 0; i < m; i++)
					if ($urandom_range(0, 7) == 0)
						send_pixel(OP_MAP, pix_t'($urandom), pix_t'($urandom), pix_t'($urandom),
							1'(i == m - 1));
					else
						send_pixel(OP_MAP, near_range(lo, hi), near_range(lo, hi),
							near_range(lo, hi), 1'(i == m - 1));
			end
		end
	endtask

	// back-to-back stream with no idling on the sender side
	task automatic test_calm_stream();
		calm = 1'b1;
		test_random_frames(sent + 150);
		calm = 1'b0;
	endtask

	// receiver holds off while the sender keeps offering map pixels
	task automatic test_backpressure();
		drain();
		calm = 1'b1;
		hold_req <= ~hold_req;
		send_pixel(OP_MEASURE, 8'd20, 8'd220, 8'd90, 1'b1);
		for (int i = 0; i < 20; i++)
			send_pixel(OP_MAP, pix_t'($urandom), pix_t'($urandom), pix_t'($urandom),
				1'(i == 19));
		calm = 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		push <= 1'b0;
		operation <= OP_MEASURE;
		red_in <= '0;
		green_in <= '0;
		blue_in <= '0;
		frame_end <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_identity_after_reset();
		test_directed_cases();
		test_calm_stream();
		test_backpressure();
		test_random_frames(ITEM_TARGET);

		drain();
		repeat (30) @(posedge clk);
		$display("sent %0d pixels: %0d measure, %0d map; %0d stretched pixels checked",
			sent, measure_seen, map_seen, results_checked);
		$display("input stalled on full for %0d cycles; %0d mismatches", full_stalls, errors);
		if (errors == 0 && expected_px.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
`default_nettype wire

/* sim.f */
+incdir+rtl
rtl/rcs_pkg.sv
rtl/rcs_front.sv
rtl/rcs_fifo.sv
rtl/rcs_back.sv
rtl/rgb_contrast_stretch.sv
verif/tb_rgb_contrast_stretch.sv
